// ----- design/assert_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication under an active-low reset.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/imh_pkg.sv -----
// Package with the types, widths and codes of the indexed min-heap.
package imh_pkg;
	localparam int CAPACITY = 1024;
	localparam int SLOT_W   = 10;
	localparam int CNT_W    = 11;
	localparam int HANDLE_W = 10;
	localparam int KEY_W    = 32;

	localparam logic [1:0] MODE_INSERT  = 2'd0;
	localparam logic [1:0] MODE_EXTRACT = 2'd1;
	localparam logic [1:0] MODE_DELETE  = 2'd2;
	localparam logic [1:0] MODE_UPDATE  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_BADH   = 2'd3;

	localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [KEY_W-1:0]    key;
	} entry_t;
endpackage

// ----- design/imh_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module imh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- design/indexed_min_heap_top.sv -----
// Indexed binary min-heap of handles ordered by key, with a handle-to-slot map.
// One operation is taken at a time and answered by one result transfer. The heap
// entries and the handle-to-slot map each live in a RAM with one write and one
// registered read port, so every level of a sift costs RAM reads: each level of
// sift down reads the left child, then the right child, then decides and moves,
// and each level of sift up reads the parent, then compares and moves. An
// operation first has its handle looked up and checked; a removal then fetches
// the last entry; then come, as the operation needs, the levels down and the
// levels up, an end step for each sift, and the output state, in which the result
// waits for the receiver. An error is answered straight after the checks. Presence
// of a handle is confirmed by the slot it maps to lying below the count and
// holding that handle. After reset a clearing pass zeroes all 1024 entries of the
// map, and no operation is accepted until it ends.
module indexed_min_heap_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     mode,
	input  logic [imh_pkg::HANDLE_W-1:0]   handle,
	input  logic [imh_pkg::KEY_W-1:0]      key,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     status,
	output logic [imh_pkg::HANDLE_W-1:0]   out_handle,
	output logic [imh_pkg::KEY_W-1:0]      out_key,
	output logic [imh_pkg::CNT_W-1:0]      occupancy
);
	import imh_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MAP  = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_LAST = 4'd3;
	localparam logic [3:0] S_DL   = 4'd4;
	localparam logic [3:0] S_DWL  = 4'd5;
	localparam logic [3:0] S_DWR  = 4'd6;
	localparam logic [3:0] S_UP   = 4'd7;
	localparam logic [3:0] S_UPW  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;
	localparam logic [3:0] S_CLR  = 4'd10;

	logic [3:0]          state_q;
	logic [HANDLE_W-1:0] clr_q;
	logic [1:0]          mode_q;
	logic [HANDLE_W-1:0] h_q;
	logic [KEY_W-1:0]    k_q;
	logic [SLOT_W-1:0]   pos_q;
	logic [CNT_W-1:0]    cnt_q;
	entry_t              cur_q;
	entry_t              lc_q;
	logic [1:0]          status_q;
	logic [HANDLE_W-1:0] oh_q;
	logic [KEY_W-1:0]    ok_q;

	logic                hp_we;
	logic [SLOT_W-1:0]   hp_waddr;
	entry_t              hp_wdata;
	logic [SLOT_W-1:0]   hp_raddr;
	entry_t              hp_rdata;
	logic                mp_we;
	logic [HANDLE_W-1:0] mp_waddr;
	logic [SLOT_W-1:0]   mp_wdata;
	logic [HANDLE_W-1:0] mp_raddr;
	logic [SLOT_W-1:0]   mp_rdata;

	logic [CNT_W:0]      lidx;
	logic [CNT_W:0]      ridx;
	logic [SLOT_W-1:0]   par;
	logic [SLOT_W-1:0]   last;
	logic [SLOT_W-1:0]   rem_pos;
	logic                present;
	logic                take_l;
	logic                take_r;
	logic                r_ok;
	entry_t              child;
	logic [SLOT_W-1:0]   child_pos;

	imh_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_heap (
		.clk   (clk),
		.we    (hp_we),
		.waddr (hp_waddr),
		.wdata (hp_wdata),
		.raddr (hp_raddr),
		.rdata (hp_rdata)
	);

	imh_ram #(.WIDTH(SLOT_W), .DEPTH(1 << HANDLE_W)) u_map (
		.clk   (clk),
		.we    (mp_we),
		.waddr (mp_waddr),
		.wdata (mp_wdata),
		.raddr (mp_raddr),
		.rdata (mp_rdata)
	);

	assign lidx    = {1'b0, pos_q, 1'b1};
	assign ridx    = {1'b0, pos_q, 1'b0} + (CNT_W+1)'(2);
	assign par     = SLOT_W'((pos_q - SLOT_W'(1)) >> 1);
	assign last    = SLOT_W'(cnt_q - CNT_W'(1));
	assign rem_pos = (mode_q == MODE_EXTRACT) ? '0 : pos_q;
	assign present = ({1'b0, pos_q} < cnt_q) && (hp_rdata.handle == h_q);
	assign r_ok    = ridx < {1'b0, cnt_q};
	assign take_l  = lc_q.key < cur_q.key;
	assign take_r  = r_ok && (hp_rdata.key < (take_l ? lc_q.key : cur_q.key));
	assign child   = take_r ? hp_rdata : lc_q;
	assign child_pos = take_r ? ridx[SLOT_W-1:0] : lidx[SLOT_W-1:0];

	always_comb begin
		hp_we    = 1'b0;
		hp_waddr = pos_q;
		hp_wdata = cur_q;
		hp_raddr = '0;
		mp_we    = 1'b0;
		mp_waddr = cur_q.handle;
		mp_wdata = pos_q;
		mp_raddr = handle;
		case (state_q)
			S_CLR: begin
				mp_we    = 1'b1;
				mp_waddr = clr_q;
				mp_wdata = '0;
			end
			S_MAP: begin
				hp_raddr = (mode_q == MODE_EXTRACT) ? '0 : mp_rdata;
			end
			S_CHK: begin
				hp_raddr = last;
			end
			S_DL: begin
				hp_raddr = lidx[SLOT_W-1:0];
			end
			S_DWL: begin
				hp_raddr = ridx[SLOT_W-1:0];
			end
			S_DWR: begin
				if (take_l || take_r) begin
					hp_we    = 1'b1;
					hp_wdata = child;
					mp_we    = 1'b1;
					mp_waddr = child.handle;
				end
			end
			S_UP: begin
				hp_raddr = par;
				if (pos_q == '0) begin
					hp_we = 1'b1;
					mp_we = 1'b1;
				end
			end
			S_UPW: begin
				hp_we = 1'b1;
				mp_we = 1'b1;
				if (cur_q.key < hp_rdata.key) begin
					hp_wdata = hp_rdata;
					mp_waddr = hp_rdata.handle;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + HANDLE_W'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MAP;
					end
				end
				S_MAP: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					state_q <= S_OUT;
					case (mode_q)
						MODE_INSERT: begin
							if (!present && cnt_q != CAP_COUNT) begin
								cnt_q   <= cnt_q + CNT_W'(1);
								state_q <= S_UP;
							end
						end
						MODE_UPDATE: begin
							if (present) begin
								state_q <= S_DL;
							end
						end
						default: begin
							if ((mode_q == MODE_EXTRACT && cnt_q != '0) ||
									(mode_q == MODE_DELETE && present)) begin
								if (rem_pos == last) begin
									cnt_q <= cnt_q - CNT_W'(1);
								end else begin
									state_q <= S_LAST;
								end
							end
						end
					endcase
				end
				S_LAST: begin
					cnt_q   <= cnt_q - CNT_W'(1);
					state_q <= S_DL;
				end
				S_DL: begin
					state_q <= (lidx < {1'b0, cnt_q}) ? S_DWL : S_UP;
				end
				S_DWL: begin
					state_q <= S_DWR;
				end
				S_DWR: begin
					state_q <= (take_l || take_r) ? S_DL : S_UP;
				end
				S_UP: begin
					state_q <= (pos_q == '0) ? S_OUT : S_UPW;
				end
				S_UPW: begin
					state_q <= (cur_q.key < hp_rdata.key) ? S_UP : S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q <= mode;
				h_q    <= handle;
				k_q    <= key;
			end
			S_MAP: begin
				pos_q <= mp_rdata;
			end
			S_CHK: begin
				status_q <= ST_OK;
				oh_q     <= '0;
				ok_q     <= '0;
				cur_q    <= '{handle: h_q, key: k_q};
				case (mode_q)
					MODE_INSERT: begin
						pos_q <= cnt_q[SLOT_W-1:0];
						if (present) begin
							status_q <= ST_BADH;
						end else if (cnt_q == CAP_COUNT) begin
							status_q <= ST_FULL;
						end
					end
					MODE_EXTRACT: begin
						pos_q <= '0;
						if (cnt_q == '0) begin
							status_q <= ST_EMPTY;
						end else begin
							oh_q <= hp_rdata.handle;
							ok_q <= hp_rdata.key;
						end
					end
					default: begin
						if (!present) begin
							status_q <= ST_BADH;
						end
					end
				endcase
			end
			S_LAST: begin
				cur_q <= hp_rdata;
			end
			S_DWL: begin
				lc_q <= hp_rdata;
			end
			S_DWR: begin
				if (take_l || take_r) begin
					pos_q <= child_pos;
				end
			end
			S_UPW: begin
				if (cur_q.key < hp_rdata.key) begin
					pos_q <= par;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign status     = status_q;
	assign out_handle = oh_q;
	assign out_key    = ok_q;
	assign occupancy  = cnt_q;
endmodule

// ----- design/indexed_min_heap_chk.sv -----
// Port-level checker for the indexed min-heap and its bind to the top level.
`include "assert_macros.svh"

module indexed_min_heap_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [1:0]                   status,
	input logic [imh_pkg::HANDLE_W-1:0] out_handle,
	input logic [imh_pkg::KEY_W-1:0]    out_key,
	input logic [imh_pkg::CNT_W-1:0]    occupancy
);
	import imh_pkg::*;

	`AST_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)
	`AST_NEXT(a_result_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status))
	`AST_IMPLY(a_empty_count, clk, arst_n, out_valid && status == ST_EMPTY, occupancy == '0)
	`AST_IMPLY(a_full_count, clk, arst_n, out_valid && status == ST_FULL, occupancy == CAP_COUNT)
	`AST_IMPLY(a_error_no_data, clk, arst_n, out_valid && status != ST_OK, out_handle == '0 && out_key == '0)
endmodule

bind indexed_min_heap_top indexed_min_heap_chk u_chk (.*);

// ----- tb/indexed_min_heap_checker.sv -----
`timescale 1ns / 100ps
// Checker for the indexed min-heap: watches both channels, keeps a heap of its own and compares.
module indexed_min_heap_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [1:0]                   mode,
	input  logic [imh_pkg::HANDLE_W-1:0] handle,
	input  logic [imh_pkg::KEY_W-1:0]    key,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [1:0]                   status,
	input  logic [imh_pkg::HANDLE_W-1:0] out_handle,
	input  logic [imh_pkg::KEY_W-1:0]    out_key,
	input  logic [imh_pkg::CNT_W-1:0]    occupancy,
	output int                           fail_count,
	output int                           pending
);
	import imh_pkg::*;

	typedef struct packed {
		logic [1:0]          st;
		logic [HANDLE_W-1:0] hd;
		logic [KEY_W-1:0]    ky;
		logic [CNT_W-1:0]    cnt;
	} heap_answer_t;

	localparam int ABSENT = -1;

	logic [HANDLE_W-1:0] heap_hd [CAPACITY];
	logic [KEY_W-1:0]    heap_ky [CAPACITY];
	int                  where_is [1024];
	int                  heap_size;
	heap_answer_t        answers_due [$];

	initial begin
		for (int i = 0; i < 1024; i++)
			where_is[i] = ABSENT;
		heap_size = 0;
		fail_count = 0;
	end

	assign pending = answers_due.size();

	task automatic report(input string what, input logic [KEY_W-1:0] got,
			input logic [KEY_W-1:0] want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic void swap_entries(input int a, input int b);
		logic [HANDLE_W-1:0] th;
		logic [KEY_W-1:0]    tk;
		th = heap_hd[a];
		tk = heap_ky[a];
		heap_hd[a] = heap_hd[b];
		heap_ky[a] = heap_ky[b];
		heap_hd[b] = th;
		heap_ky[b] = tk;
		where_is[heap_hd[a]] = a;
		where_is[heap_hd[b]] = b;
	endfunction

	function automatic int push_down(input int p);
		int l;
		int r;
		int m;
		forever begin
			l = 2 * p + 1;
			r = 2 * p + 2;
			m = p;
			if (l < heap_size && heap_ky[l] < heap_ky[m])
				m = l;
			if (r < heap_size && heap_ky[r] < heap_ky[m])
				m = r;
			if (m == p)
				return p;
			swap_entries(p, m);
			p = m;
		end
	endfunction

	function automatic void bubble_up(input int p);
		int q;
		while (p > 0) begin
			q = (p - 1) / 2;
			if (!(heap_ky[p] < heap_ky[q]))
				return;
			swap_entries(p, q);
			p = q;
		end
	endfunction

	function automatic void take_slot(input int p);
		int last;
		last = heap_size - 1;
		where_is[heap_hd[p]] = ABSENT;
		heap_size = last;
		if (p == last)
			return;
		heap_hd[p] = heap_hd[last];
		heap_ky[p] = heap_ky[last];
		where_is[heap_hd[p]] = p;
		bubble_up(push_down(p));
	endfunction

	function automatic heap_answer_t apply_op(input logic [1:0] op,
			input logic [HANDLE_W-1:0] h, input logic [KEY_W-1:0] k);
		heap_answer_t a;
		int p;
		bit here;
		a = '0;
		p = where_is[h];
		here = p != ABSENT && p < heap_size;
		case (op)
			MODE_INSERT: begin
				if (here)
					a.st = ST_BADH;
				else if (heap_size >= CAPACITY)
					a.st = ST_FULL;
				else begin
					heap_hd[heap_size] = h;
					heap_ky[heap_size] = k;
					where_is[h] = heap_size;
					heap_size++;
					bubble_up(heap_size - 1);
				end
			end
			MODE_EXTRACT: begin
				if (heap_size == 0)
					a.st = ST_EMPTY;
				else begin
					a.hd = heap_hd[0];
					a.ky = heap_ky[0];
					take_slot(0);
				end
			end
			MODE_DELETE: begin
				if (!here)
					a.st = ST_BADH;
				else
					take_slot(p);
			end
			default: begin
				if (!here)
					a.st = ST_BADH;
				else begin
					heap_ky[p] = k;
					bubble_up(push_down(p));
				end
			end
		endcase
		a.cnt = CNT_W'(heap_size);
		return a;
	endfunction

	always @(posedge clk) begin
		heap_answer_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				answers_due = {answers_due, apply_op(mode, handle, key)};
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					report("unexpected result status", KEY_W'(status), '0);
				end else begin
					want = answers_due.pop_front();
					if (status !== want.st)
						report("status", status, want.st);
					if (out_handle !== want.hd)
						report("out_handle", out_handle, want.hd);
					if (out_key !== want.ky)
						report("out_key", out_key, want.ky);
					if (occupancy !== want.cnt)
						report("occupancy", occupancy, want.cnt);
				end
			end
		end
	end
endmodule

// ----- tb/indexed_min_heap_top_test.sv -----
`timescale 1ns / 100ps
// Top of the indexed min-heap testbench: clock, reset, stimulus and verdict.
module indexed_min_heap_top_test;
	import imh_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          mode;
	logic [HANDLE_W-1:0] handle;
	logic [KEY_W-1:0]    key;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          status;
	logic [HANDLE_W-1:0] out_handle;
	logic [KEY_W-1:0]    out_key;
	logic [CNT_W-1:0]    occupancy;
	int                  fail_count;
	int                  pending;
	int                  hold_off;
	bit                  sending_done;
	logic [HANDLE_W-1:0] live_handles [$];

	indexed_min_heap_top dut (.*);

	indexed_min_heap_checker watch (.*);

	initial begin
		clk = 1'b0;
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		in_valid = 1'b0;
		out_ready = 1'b0;
		mode = MODE_INSERT;
		handle = '0;
		key = '0;
		hold_off = 0;
		sending_done = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	// The receiver stalls on a shifting pattern, with one long hold-off.
	always @(posedge clk) begin
		int phase;
		if (arst_n) begin
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else begin
				phase = $urandom_range(0, 9);
				out_ready <= (phase < 6) || ($time / 4000) % 3 == 0;
			end
		end
	end

	task automatic send_op(input logic [1:0] op, input logic [HANDLE_W-1:0] h,
			input logic [KEY_W-1:0] k);
		in_valid <= 1'b1;
		mode <= op;
		handle <= h;
		key <= k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic idle_gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 6))
			@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return KEY_W'($urandom_range(0, 7));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [HANDLE_W-1:0] pick_handle();
		if (live_handles.size() > 0 && $urandom_range(0, 4) != 0)
			return live_handles[$urandom_range(0, live_handles.size() - 1)];
		return HANDLE_W'($urandom);
	endfunction

	initial begin
		int burst;
		int fill_to;
		logic [1:0] op;
		logic [HANDLE_W-1:0] h;
		@(posedge arst_n);
		@(posedge clk);
		send_op(MODE_EXTRACT, 10'd0, '0);
		send_op(MODE_DELETE, 10'd5, '0);
		send_op(MODE_UPDATE, 10'd5, 32'd1);
		send_op(MODE_INSERT, 10'd0, 32'hFFFF_FFFF);
		send_op(MODE_INSERT, 10'd1023, 32'd0);
		send_op(MODE_INSERT, 10'd1023, 32'd7);
		send_op(MODE_INSERT, 10'h2AA, 32'h5555_5555);
		send_op(MODE_INSERT, 10'h155, 32'hAAAA_AAAA);
		send_op(MODE_INSERT, 10'd9, 32'h5555_5555);
		send_op(MODE_UPDATE, 10'd1023, 32'hFFFF_FFFE);
		send_op(MODE_UPDATE, 10'd0, 32'd0);
		send_op(MODE_DELETE, 10'd9, '0);
		send_op(MODE_DELETE, 10'h2AA, '0);
		send_op(MODE_EXTRACT, 10'd0, '0);
		send_op(MODE_EXTRACT, 10'd0, '0);
		send_op(MODE_EXTRACT, 10'd0, '0);
		send_op(MODE_EXTRACT, 10'd0, '0);
		idle_gap();

		// Set a receiver hold-off, fill the heap to capacity, then keep inserting.
		hold_off = 400;
		for (int i = 0; i < CAPACITY; i++) begin
			send_op(MODE_INSERT, HANDLE_W'(i), pick_key());
			live_handles = {live_handles, HANDLE_W'(i)};
		end
		send_op(MODE_INSERT, 10'd77, 32'd1);
		send_op(MODE_INSERT, 10'd3, 32'd1);
		send_op(MODE_UPDATE, 10'd512, 32'd0);
		send_op(MODE_DELETE, 10'd1023, '0);
		send_op(MODE_INSERT, 10'd1023, 32'd4);
		idle_gap();

		for (int n = 0; n < 250; ) begin
			burst = $urandom_range(1, 20);
			for (int b = 0; b < burst; b++) begin
				op = 2'($urandom_range(0, 3));
				h = pick_handle();
				if (op == MODE_INSERT) begin
					h = HANDLE_W'($urandom);
					live_handles = {live_handles, h};
				end
				send_op(op, h, pick_key());
				n++;
			end
			fill_to = $urandom_range(0, 3);
			if (fill_to != 0)
				idle_gap();
		end
		in_valid <= 1'b0;
		sending_done = 1'b1;
	end

	initial begin
		wait (sending_done);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// ----- indexed_min_heap_top.f -----
+incdir+design
design/imh_pkg.sv
design/imh_ram.sv
design/indexed_min_heap_top.sv
design/indexed_min_heap_chk.sv
tb/indexed_min_heap_checker.sv
tb/indexed_min_heap_top_test.sv
